// ===== design/fcs_pkg.sv =====
// fcs_pkg: request/result structs, operation, result-kind and register codes
// for the FIFO counting semaphore. No dependencies.
`timescale 1ns / 1ps

package fcs_pkg;

  localparam int unsigned PERMIT_W  = 32;
  localparam int unsigned TAG_W     = 8;
  localparam int unsigned OP_W      = 2;
  localparam int unsigned KIND_W    = 3;
  localparam int unsigned CFG_IDX_W = 1;
  localparam int unsigned GRANT_CAP = 16;
  localparam int unsigned GRANT_CNT_W = $clog2(GRANT_CAP + 1);

  // Operation codes
  localparam logic [OP_W-1:0] OP_ACQUIRE = 2'd0;
  localparam logic [OP_W-1:0] OP_TRY     = 2'd1;
  localparam logic [OP_W-1:0] OP_RELEASE = 2'd2;
  localparam logic [OP_W-1:0] OP_CANCEL  = 2'd3;

  // Result kinds
  localparam logic [KIND_W-1:0] KIND_GRANTED  = 3'd0;
  localparam logic [KIND_W-1:0] KIND_QUEUED   = 3'd1;
  localparam logic [KIND_W-1:0] KIND_REFUSED  = 3'd2;
  localparam logic [KIND_W-1:0] KIND_FULL     = 3'd3;
  localparam logic [KIND_W-1:0] KIND_NO_GRANT = 3'd4;
  localparam logic [KIND_W-1:0] KIND_ERROR    = 3'd5;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_LIMIT_ENABLED = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_PERMITS   = 1'd1;

  typedef struct packed {
    logic [OP_W-1:0]     op;
    logic [PERMIT_W-1:0] permits;
    logic [TAG_W-1:0]    waiter_tag;
  } req_t;

  typedef struct packed {
    logic [KIND_W-1:0]   kind;
    logic [TAG_W-1:0]    tag;
    logic [PERMIT_W-1:0] granted;
    logic [PERMIT_W-1:0] in_use;
    logic                last;
  } res_t;

endpackage

// ===== design/fcs_ram.sv =====
// fcs_ram: generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module fcs_ram #(
  parameter int unsigned WIDTH = 40,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== design/fifo_counting_semaphore.sv =====
// fifo_counting_semaphore: top level of the FIFO-fair counting semaphore.
// Depends on fcs_pkg (types, codes) and fcs_ram (waiter queue storage).
`timescale 1ns / 1ps
//
//  channel    | ports                                  | handshake
//  -----------+----------------------------------------+------------------------------
//  request    | start, busy, req_i                     | taken when start && !busy
//  config     | cfg_valid_i, cfg_ready_o, cfg_index_i,  | write when valid && ready
//             | cfg_data_i                             | (ready always high)
//  result     | res_valid_o, res_o                     | one-cycle strobe, no stall
//
//  Acquire / try-acquire drop each dead queue-head entry in S_ACQ, then decide. Release is
//  checked in S_REL. Cancel reads each scanned entry from the RAM (S_CAN_RD, then S_CAN_CHK)
//  and reports an unknown tag from S_CAN_RD. Either then walks the head: S_SRV_DROP per dead
//  entry, S_SRV_DROP and S_SRV_CHK per grant (RAM read plus fit check on the shared
//  adder/comparator), S_SRV_DROP to finish, or S_SRV_CHK when the head waiter does not fit.
//  The waiter queue RAM's registered read port sets the grant pace. The result appears the
//  cycle after it is formed, and busy drops in the same cycle as the last result's strobe.
//  Reset clears held permits, queue pointers and live bits; the queue RAM is not
//  cleared, since an entry is only read after it was written. The receiver cannot
//  stall: every result is strobed exactly once.

module fifo_counting_semaphore #(
  parameter int unsigned QUEUE_DEPTH = 16
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start,
  output logic                                busy,
  input  fcs_pkg::req_t                       req_i,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [fcs_pkg::CFG_IDX_W-1:0]       cfg_index_i,
  input  logic [fcs_pkg::PERMIT_W-1:0]        cfg_data_i,
  output logic                                res_valid_o,
  output fcs_pkg::res_t                       res_o
);

  localparam int unsigned IDX_W  = $clog2(QUEUE_DEPTH);
  localparam int unsigned CNT_W  = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned PTR_W  = IDX_W + 1;
  localparam int unsigned ENTRY_W = fcs_pkg::PERMIT_W + fcs_pkg::TAG_W;
  localparam int unsigned PW     = fcs_pkg::PERMIT_W;

  typedef enum logic [6:0] {
    S_IDLE     = 7'b0000001,
    S_ACQ      = 7'b0000010,
    S_REL      = 7'b0000100,
    S_CAN_RD   = 7'b0001000,
    S_CAN_CHK  = 7'b0010000,
    S_SRV_DROP = 7'b0100000,
    S_SRV_CHK  = 7'b1000000
  } state_e;

  state_e state_q, state_d;

  // Configuration registers
  logic          limit_en_q;
  logic [PW-1:0] max_permits_q;

  // Semaphore state
  logic [PW-1:0]          held_q, held_d;
  logic [IDX_W-1:0]       head_q, head_d;
  logic [CNT_W-1:0]       count_q, count_d;
  logic [QUEUE_DEPTH-1:0] live_q, live_d;

  // Sequencer working registers
  fcs_pkg::req_t                   req_q;
  logic [IDX_W-1:0]                scan_q, scan_d;
  logic [CNT_W-1:0]                left_q, left_d;
  logic [fcs_pkg::GRANT_CNT_W-1:0] ngrant_q, ngrant_d;
  logic                            pend_valid_q, pend_valid_d;
  fcs_pkg::res_t                   pend_q, pend_d;

  // Output register
  logic          res_valid_q, res_valid_d;
  fcs_pkg::res_t res_q, res_d;

  // Queue RAM
  logic                 ram_we;
  logic [IDX_W-1:0]     ram_waddr;
  logic [IDX_W-1:0]     ram_raddr;
  logic [ENTRY_W-1:0]   ram_rdata;
  logic [PW-1:0]        ram_amt;
  logic [fcs_pkg::TAG_W-1:0] ram_tag;

  // Shared fit unit
  logic [PW-1:0] fit_p;
  logic [PW:0]   fit_sum;
  logic          fit_ok;

  // Release check
  logic [PW:0]   rel_diff;
  logic          rel_bad;

  logic [PTR_W-1:0] tail_sum;
  logic [IDX_W-1:0] tail;
  logic             head_dead;

  function automatic logic [IDX_W-1:0] wrap_inc(input logic [IDX_W-1:0] idx);
    return (idx == IDX_W'(QUEUE_DEPTH - 1)) ? '0 : idx + 1'b1;
  endfunction

  assign busy        = (state_q != S_IDLE);
  assign cfg_ready_o = 1'b1;
  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

  assign ram_amt = ram_rdata[ENTRY_W-1 -: PW];
  assign ram_tag = ram_rdata[fcs_pkg::TAG_W-1:0];

  // Fit: no 32-bit overflow, and the limit holds unless nothing is held
  assign fit_p   = (state_q == S_SRV_CHK) ? ram_amt : req_q.permits;
  assign fit_sum = {1'b0, held_q} + {1'b0, fit_p};
  assign fit_ok  = !fit_sum[PW] &&
                   (!limit_en_q || (held_q == '0) || (fit_sum[PW-1:0] <= max_permits_q));

  assign rel_diff = {1'b0, held_q} - {1'b0, req_q.permits};
  assign rel_bad  = (req_q.permits == '0) || rel_diff[PW];

  assign tail_sum = PTR_W'(head_q) + PTR_W'(count_q);
  assign tail     = (tail_sum >= PTR_W'(QUEUE_DEPTH)) ?
                    IDX_W'(tail_sum - PTR_W'(QUEUE_DEPTH)) : IDX_W'(tail_sum);

  assign head_dead = (count_q != '0) && !live_q[head_q];

  assign ram_raddr = (state_q == S_CAN_RD) ? scan_q : head_q;
  assign ram_waddr = tail;

  fcs_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i ({req_q.permits, req_q.waiter_tag}),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  always_comb begin
    state_d      = state_q;
    held_d       = held_q;
    head_d       = head_q;
    count_d      = count_q;
    live_d       = live_q;
    scan_d       = scan_q;
    left_d       = left_q;
    ngrant_d     = ngrant_q;
    pend_valid_d = pend_valid_q;
    pend_d       = pend_q;
    res_valid_d  = 1'b0;
    res_d        = res_q;
    ram_we       = 1'b0;

    unique case (state_q)
      S_IDLE: begin
        if (start) begin
          unique case (req_i.op)
            fcs_pkg::OP_ACQUIRE, fcs_pkg::OP_TRY: state_d = S_ACQ;
            fcs_pkg::OP_RELEASE:                  state_d = S_REL;
            fcs_pkg::OP_CANCEL: begin
              scan_d  = head_q;
              left_d  = count_q;
              state_d = S_CAN_RD;
            end
            default: state_d = S_IDLE;
          endcase
        end
      end

      S_ACQ: begin
        if (head_dead) begin
          // drop a cancelled head entry
          head_d  = wrap_inc(head_q);
          count_d = count_q - 1'b1;
        end else begin
          res_valid_d   = 1'b1;
          res_d.tag     = req_q.waiter_tag;
          res_d.granted = '0;
          res_d.in_use  = held_q;
          res_d.last    = 1'b1;
          if ((count_q == '0) && fit_ok) begin
            held_d        = fit_sum[PW-1:0];
            res_d.kind    = fcs_pkg::KIND_GRANTED;
            res_d.granted = req_q.permits;
            res_d.in_use  = fit_sum[PW-1:0];
          end else if (req_q.op == fcs_pkg::OP_TRY) begin
            res_d.kind = fcs_pkg::KIND_REFUSED;
          end else if (count_q >= CNT_W'(QUEUE_DEPTH)) begin
            res_d.kind = fcs_pkg::KIND_FULL;
          end else begin
            // enqueue at the tail
            ram_we       = 1'b1;
            live_d[tail] = 1'b1;
            count_d      = count_q + 1'b1;
            res_d.kind   = fcs_pkg::KIND_QUEUED;
          end
          state_d = S_IDLE;
        end
      end

      S_REL: begin
        if (rel_bad) begin
          res_valid_d   = 1'b1;
          res_d.kind    = fcs_pkg::KIND_ERROR;
          res_d.tag     = req_q.waiter_tag;
          res_d.granted = '0;
          res_d.in_use  = held_q;
          res_d.last    = 1'b1;
          state_d       = S_IDLE;
        end else begin
          held_d       = rel_diff[PW-1:0];
          ngrant_d     = '0;
          pend_valid_d = 1'b0;
          state_d      = S_SRV_DROP;
        end
      end

      S_CAN_RD: begin
        if (left_q == '0) begin
          // unknown tag
          res_valid_d   = 1'b1;
          res_d.kind    = fcs_pkg::KIND_ERROR;
          res_d.tag     = req_q.waiter_tag;
          res_d.granted = '0;
          res_d.in_use  = held_q;
          res_d.last    = 1'b1;
          state_d       = S_IDLE;
        end else begin
          state_d = S_CAN_CHK;
        end
      end

      S_CAN_CHK: begin
        if (live_q[scan_q] && (ram_tag == req_q.waiter_tag)) begin
          live_d[scan_q] = 1'b0;
          ngrant_d       = '0;
          pend_valid_d   = 1'b0;
          state_d        = S_SRV_DROP;
        end else begin
          scan_d  = wrap_inc(scan_q);
          left_d  = left_q - 1'b1;
          state_d = S_CAN_RD;
        end
      end

      S_SRV_DROP: begin
        if (head_dead) begin
          head_d  = wrap_inc(head_q);
          count_d = count_q - 1'b1;
        end else if ((count_q == '0) ||
                     (ngrant_q >= fcs_pkg::GRANT_CNT_W'(fcs_pkg::GRANT_CAP))) begin
          // finish: flush the held grant as last, or report no grant
          res_valid_d = 1'b1;
          if (pend_valid_q) begin
            res_d      = pend_q;
            res_d.last = 1'b1;
          end else begin
            res_d.kind    = fcs_pkg::KIND_NO_GRANT;
            res_d.tag     = req_q.waiter_tag;
            res_d.granted = '0;
            res_d.in_use  = held_q;
            res_d.last    = 1'b1;
          end
          pend_valid_d = 1'b0;
          state_d      = S_IDLE;
        end else begin
          // head address is on the RAM read port this cycle
          state_d = S_SRV_CHK;
        end
      end

      S_SRV_CHK: begin
        if (fit_ok) begin
          held_d         = fit_sum[PW-1:0];
          live_d[head_q] = 1'b0;
          head_d         = wrap_inc(head_q);
          count_d        = count_q - 1'b1;
          ngrant_d       = ngrant_q + 1'b1;
          // hold the new grant until the next one shows whether it is last
          if (pend_valid_q) begin
            res_valid_d = 1'b1;
            res_d       = pend_q;
            res_d.last  = 1'b0;
          end
          pend_valid_d   = 1'b1;
          pend_d.kind    = fcs_pkg::KIND_GRANTED;
          pend_d.tag     = ram_tag;
          pend_d.granted = ram_amt;
          pend_d.in_use  = fit_sum[PW-1:0];
          pend_d.last    = 1'b0;
          state_d        = S_SRV_DROP;
        end else begin
          res_valid_d = 1'b1;
          if (pend_valid_q) begin
            res_d      = pend_q;
            res_d.last = 1'b1;
          end else begin
            res_d.kind    = fcs_pkg::KIND_NO_GRANT;
            res_d.tag     = req_q.waiter_tag;
            res_d.granted = '0;
            res_d.in_use  = held_q;
            res_d.last    = 1'b1;
          end
          pend_valid_d = 1'b0;
          state_d      = S_IDLE;
        end
      end

      default: state_d = S_IDLE;
    endcase
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= S_IDLE;
      limit_en_q    <= 1'b1;
      max_permits_q <= PW'(1);
      held_q        <= '0;
      head_q        <= '0;
      count_q       <= '0;
      live_q        <= '0;
      scan_q        <= '0;
      left_q        <= '0;
      ngrant_q      <= '0;
      pend_valid_q  <= 1'b0;
      res_valid_q   <= 1'b0;
    end else begin
      state_q      <= state_d;
      held_q       <= held_d;
      head_q       <= head_d;
      count_q      <= count_d;
      live_q       <= live_d;
      scan_q       <= scan_d;
      left_q       <= left_d;
      ngrant_q     <= ngrant_d;
      pend_valid_q <= pend_valid_d;
      res_valid_q  <= res_valid_d;
      if (cfg_valid_i && cfg_ready_o) begin
        unique case (cfg_index_i)
          fcs_pkg::CFG_LIMIT_ENABLED: limit_en_q    <= cfg_data_i[0];
          fcs_pkg::CFG_MAX_PERMITS:   max_permits_q <= cfg_data_i;
          default:                    limit_en_q    <= limit_en_q;
        endcase
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (start && !busy) begin
      req_q <= req_i;
    end
    pend_q <= pend_d;
    res_q  <= res_d;
  end

endmodule
